/* hw/rtl/tcbc_pkg.sv */
// Shared types and constants for the two-class blob centroid unit.
package tcbc_pkg;

  // Field widths
  localparam int unsigned COORD_W  = 11;
  localparam int unsigned SKIP_W   = 5;
  localparam int unsigned FRAME_W  = 12;
  localparam int unsigned CNT_W    = 23;
  localparam int unsigned SUM_W    = 33;
  localparam int unsigned LOC_W    = 12;
  localparam int unsigned ADDR_W   = 3;

  // Shared divider geometry
  localparam int unsigned DIV_W    = SUM_W;
  localparam int unsigned DVSR_W   = CNT_W;
  localparam int unsigned STEP_W   = $clog2(DIV_W + 1);

  // Register indexes
  localparam logic [ADDR_W-1:0] REG_PIXEL_SKIP  = 3'd0;
  localparam logic [ADDR_W-1:0] REG_FRAME_W     = 3'd1;
  localparam logic [ADDR_W-1:0] REG_FRAME_H     = 3'd2;
  localparam logic [ADDR_W-1:0] REG_FIRST_MIN   = 3'd3;
  localparam logic [ADDR_W-1:0] REG_SECOND_MIN  = 3'd4;

  // Register reset values
  localparam logic [SKIP_W-1:0]  RST_PIXEL_SKIP = 5'd2;
  localparam logic [FRAME_W-1:0] RST_FRAME_W    = 12'd640;
  localparam logic [FRAME_W-1:0] RST_FRAME_H    = 12'd480;
  localparam logic [CNT_W-1:0]   RST_FIRST_MIN  = 23'd60;
  localparam logic [CNT_W-1:0]   RST_SECOND_MIN = 23'd30;

  // Saturation bounds of a location
  localparam logic signed [SUM_W+1:0] LOC_MAX = 35'sd2047;
  localparam logic signed [SUM_W+1:0] LOC_MIN = -35'sd2048;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MODC,
    ST_MODR,
    ST_FIN,
    ST_D1C,
    ST_D1R,
    ST_D2C,
    ST_D2R,
    ST_EMIT
  } tcbc_state_t;

  // Divider request: dividend is left aligned for the number of steps
  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [DVSR_W-1:0] divisor;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  // Divider status and results
  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DIV_W-1:0]  quotient;
    logic [DVSR_W-1:0] remainder;
  } div_rsp_t;

endpackage

/* hw/rtl/tcbc_divider.sv */
// Bit-serial restoring divider shared by the modulo checks and the centroid divisions.
module tcbc_divider
  import tcbc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DIV_W-1:0]  quo_r;
  logic [DVSR_W-1:0] rem_r;
  logic [DVSR_W-1:0] dvsr_r;
  logic [STEP_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;

  logic [DVSR_W:0]   rem_sh;
  logic [DVSR_W+1:0] diff;

  // Shift in the next dividend bit and trial subtract
  always_comb begin
    rem_sh = {rem_r, quo_r[DIV_W-1]};
    diff   = {1'b0, rem_sh} - {2'b00, dvsr_r};
  end

  // Control: count down steps, pulse done after the last one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r  <= req.dividend;
      rem_r  <= '0;
      dvsr_r <= req.divisor;
    end else if (busy_r) begin
      if (!diff[DVSR_W+1]) begin
        rem_r <= diff[DVSR_W-1:0];
        quo_r <= {quo_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[DVSR_W-1:0];
        quo_r <= {quo_r[DIV_W-2:0], 1'b0};
      end
    end
  end

  assign rsp.busy      = busy_r;
  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

endmodule

/* hw/rtl/two_class_blob_centroid_unit.sv */
// Top level: per-class pixel accumulation and frame-end centroid report.
// A pixel with no class hit, or outside the frame, is not sent to the divider.
// A hit pixel inside the frame runs up to two 11-step modulo checks on the divider: column, then row.
// A frame-end beat adds up to four 33-step divisions, one per axis of each found class.
// Throughput is bounded by the single shared bit-serial divider; one beat is in work at a time.
// Synchronous active-low reset clears counts and sums, sets held locations to -1 and
// loads the register defaults; the result register is emptied.
module two_class_blob_centroid_unit
  import tcbc_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_HEIGHT = 2048
) (
  input  logic              clk,
  input  logic              rst_n,
  // Input stream
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [23:0]       in_tdata,   // col_index[10:0], row_index[21:11], zero pad
  input  logic              in_tlast,   // frame_end
  input  logic [1:0]        in_tuser,   // first_hit[0], second_hit[1]
  // Result stream
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [47:0]       out_tdata,  // first_x, first_y, second_x, second_y (12 bits each)
  output logic [1:0]        out_tuser,  // first_found[0], second_found[1]
  // Configuration writes
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [ADDR_W-1:0] cfg_addr,
  input  logic [CNT_W-1:0]  cfg_data
);

  localparam int unsigned PAD_W = DIV_W - COORD_W;

  // Configuration registers
  logic [SKIP_W-1:0]  skip_r;
  logic [FRAME_W-1:0] width_r;
  logic [FRAME_W-1:0] height_r;
  logic [CNT_W-1:0]   min1_r;
  logic [CNT_W-1:0]   min2_r;

  // Accumulators and held locations
  logic [CNT_W-1:0]        cnt1_r, cnt2_r;
  logic [SUM_W-1:0]        csum1_r, rsum1_r, csum2_r, rsum2_r;
  logic signed [LOC_W-1:0] x1_r, y1_r, x2_r, y2_r;

  // Latched beat
  logic [COORD_W-1:0] col_r, row_r;
  logic               hit1_r, hit2_r, last_r;
  logic               found1_r, found2_r;

  // Result register
  logic               out_valid_r;
  logic [47:0]        out_data_r;
  logic [1:0]         out_user_r;

  tcbc_state_t state_r, state_nxt;
  div_req_t    req;
  div_rsp_t    rsp;

  logic [COORD_W-1:0] in_col, in_row;
  logic               in_acc, in_qual;
  logic               found1, found2;
  logic               mod_zero;
  logic [DVSR_W-1:0]  skip_div;
  logic               out_free;
  logic [FRAME_W-1:0] cfg_frame;
  logic signed [SUM_W+1:0] half_w, half_h, quo_s, x_raw, y_raw;
  logic signed [LOC_W-1:0] x_sat, y_sat;

  assign in_col    = in_tdata[COORD_W-1:0];
  assign in_row    = in_tdata[2*COORD_W-1:COORD_W];
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign in_qual   = (in_tuser[0] || in_tuser[1])
                     && ({1'b0, in_col} < width_r) && ({1'b0, in_row} < height_r);
  assign found1    = cnt1_r > min1_r;
  assign found2    = cnt2_r > min2_r;
  assign mod_zero  = (rsp.remainder == '0);
  assign skip_div  = (skip_r == '0) ? DVSR_W'(1) : {{(DVSR_W-SKIP_W){1'b0}}, skip_r};
  assign out_free  = !out_valid_r || out_tready;
  assign cfg_frame = cfg_data[FRAME_W-1:0];

  // Centroid offset and saturation from the divider quotient
  always_comb begin
    half_w = $signed({{(SUM_W+3-FRAME_W){1'b0}}, width_r[FRAME_W-1:1]});
    half_h = $signed({{(SUM_W+3-FRAME_W){1'b0}}, height_r[FRAME_W-1:1]});
    quo_s  = $signed({2'b00, rsp.quotient});
    x_raw  = quo_s - half_w;
    y_raw  = half_h - quo_s;
    if (x_raw > LOC_MAX)      x_sat = LOC_MAX[LOC_W-1:0];
    else if (x_raw < LOC_MIN) x_sat = LOC_MIN[LOC_W-1:0];
    else                      x_sat = x_raw[LOC_W-1:0];
    if (y_raw > LOC_MAX)      y_sat = LOC_MAX[LOC_W-1:0];
    else if (y_raw < LOC_MIN) y_sat = LOC_MIN[LOC_W-1:0];
    else                      y_sat = y_raw[LOC_W-1:0];
  end

  tcbc_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_qual)       state_nxt = ST_MODC;
          else if (in_tlast) state_nxt = ST_FIN;
        end
      end
      ST_MODC: begin
        if (rsp.done) begin
          if (mod_zero)    state_nxt = ST_MODR;
          else if (last_r) state_nxt = ST_FIN;
          else             state_nxt = ST_IDLE;
        end
      end
      ST_MODR: begin
        if (rsp.done) state_nxt = last_r ? ST_FIN : ST_IDLE;
      end
      ST_FIN: begin
        if (found1)      state_nxt = ST_D1C;
        else if (found2) state_nxt = ST_D2C;
        else             state_nxt = ST_EMIT;
      end
      ST_D1C: if (rsp.done) state_nxt = ST_D1R;
      ST_D1R: if (rsp.done) state_nxt = found2_r ? ST_D2C : ST_EMIT;
      ST_D2C: if (rsp.done) state_nxt = ST_D2R;
      ST_D2R: if (rsp.done) state_nxt = ST_EMIT;
      ST_EMIT: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Divider requests
  always_comb begin
    req.start    = 1'b0;
    req.dividend = {in_col, {PAD_W{1'b0}}};
    req.divisor  = skip_div;
    req.steps    = STEP_W'(COORD_W);
    unique case (state_r)
      ST_IDLE: req.start = in_acc && in_qual;
      ST_MODC: begin
        req.dividend = {row_r, {PAD_W{1'b0}}};
        req.start    = rsp.done && mod_zero;
      end
      ST_FIN: begin
        req.steps = STEP_W'(DIV_W);
        if (found1) begin
          req.start    = 1'b1;
          req.dividend = csum1_r;
          req.divisor  = cnt1_r;
        end else if (found2) begin
          req.start    = 1'b1;
          req.dividend = csum2_r;
          req.divisor  = cnt2_r;
        end
      end
      ST_D1C: begin
        req.steps    = STEP_W'(DIV_W);
        req.dividend = rsum1_r;
        req.divisor  = cnt1_r;
        req.start    = rsp.done;
      end
      ST_D1R: begin
        req.steps    = STEP_W'(DIV_W);
        req.dividend = csum2_r;
        req.divisor  = cnt2_r;
        req.start    = rsp.done && found2_r;
      end
      ST_D2C: begin
        req.steps    = STEP_W'(DIV_W);
        req.dividend = rsum2_r;
        req.divisor  = cnt2_r;
        req.start    = rsp.done;
      end
      ST_MODR, ST_D2R, ST_EMIT: req.start = 1'b0;
      default: req.start = 1'b0;
    endcase
  end

  // Advance sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // Take configuration writes, clamp frame size
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_r   <= RST_PIXEL_SKIP;
      width_r  <= RST_FRAME_W;
      height_r <= RST_FRAME_H;
      min1_r   <= RST_FIRST_MIN;
      min2_r   <= RST_SECOND_MIN;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_addr)
        REG_PIXEL_SKIP: skip_r <= cfg_data[SKIP_W-1:0];
        REG_FRAME_W: begin
          if ({1'b0, cfg_frame} > (FRAME_W+1)'(MAX_WIDTH)) width_r <= FRAME_W'(MAX_WIDTH);
          else                                               width_r <= cfg_frame;
        end
        REG_FRAME_H: begin
          if ({1'b0, cfg_frame} > (FRAME_W+1)'(MAX_HEIGHT)) height_r <= FRAME_W'(MAX_HEIGHT);
          else                                                height_r <= cfg_frame;
        end
        REG_FIRST_MIN:  min1_r <= cfg_data;
        REG_SECOND_MIN: min2_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Hold the accepted beat and the found flags
  always_ff @(posedge clk) begin
    if (in_acc) begin
      col_r  <= in_col;
      row_r  <= in_row;
      hit1_r <= in_tuser[0];
      hit2_r <= in_tuser[1];
      last_r <= in_tlast;
    end
    if (state_r == ST_FIN) begin
      found1_r <= found1;
      found2_r <= found2;
    end
  end

  // Accumulate hits, update held locations, clear on emit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt1_r  <= '0;
      cnt2_r  <= '0;
      csum1_r <= '0;
      rsum1_r <= '0;
      csum2_r <= '0;
      rsum2_r <= '0;
      x1_r    <= '1;
      y1_r    <= '1;
      x2_r    <= '1;
      y2_r    <= '1;
    end else begin
      if (state_r == ST_MODR && rsp.done && mod_zero) begin
        if (hit1_r) begin
          cnt1_r  <= cnt1_r + 1'b1;
          csum1_r <= csum1_r + {{PAD_W{1'b0}}, col_r};
          rsum1_r <= rsum1_r + {{PAD_W{1'b0}}, row_r};
        end
        if (hit2_r) begin
          cnt2_r  <= cnt2_r + 1'b1;
          csum2_r <= csum2_r + {{PAD_W{1'b0}}, col_r};
          rsum2_r <= rsum2_r + {{PAD_W{1'b0}}, row_r};
        end
      end
      if (rsp.done) begin
        if (state_r == ST_D1C) x1_r <= x_sat;
        if (state_r == ST_D1R) y1_r <= y_sat;
        if (state_r == ST_D2C) x2_r <= x_sat;
        if (state_r == ST_D2R) y2_r <= y_sat;
      end
      if (state_r == ST_EMIT && out_free) begin
        cnt1_r  <= '0;
        cnt2_r  <= '0;
        csum1_r <= '0;
        rsum1_r <= '0;
        csum2_r <= '0;
        rsum2_r <= '0;
      end
    end
  end

  // Load the result register, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_EMIT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_EMIT && out_free) begin
      out_data_r <= {y2_r, x2_r, y1_r, x1_r};
      out_user_r <= {found2_r, found1_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // Divider results arrive only while the sequencer waits for them
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |-> (state_r == ST_MODC || state_r == ST_MODR || state_r == ST_D1C
                  || state_r == ST_D1R || state_r == ST_D2C || state_r == ST_D2R))
    else $error("divider result outside a wait state");

  // Never restart the divider mid-run
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !rsp.busy)
    else $error("divider started while busy");

  // Accumulators are empty right after a result is loaded
  a_clear_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && out_free) |=> (cnt1_r == '0 && cnt2_r == '0 && out_valid_r))
    else $error("accumulators not cleared after frame end");

  // Input is refused while a beat is in work
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.busy |-> !in_tready)
    else $error("input ready during divider run");

endmodule
